// ===== rtl/fes_pkg.sv =====
// Shared constants and types for the floored equal share block.
package fes_pkg;

	localparam int IN_W    = 16;
	localparam int SHARE_W = 19;

	typedef enum logic {
		MODE_EVEN,
		MODE_REST
	} emit_mode_t;

endpackage

// ===== rtl/fes_ram.sv =====
// Floor store: single-port-write, registered-read memory.
module fes_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 15,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/fes_div.sv =====
// Restoring divider, one quotient bit per cycle.
module fes_div #(
	parameter int DIVIDEND_W = 20,
	parameter int DIVISOR_W  = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient,
	output logic [DIVISOR_W-1:0]  remainder
);

	localparam int CW = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CW-1:0]         cnt_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  qbit;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign qbit  = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], qbit};
			rem_q <= qbit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/floored_equal_share.sv =====
// Top level of the floored equal share block: list loader, sequencer and result register.
//
// Entries load one per cycle into the floor store while sizes and floors are summed.
// The final entry starts a run: a bit-serial division of the total by the entry
// count, then, when the floors do not cover the total, a scan of the floor store that
// reads each entry and then accumulates it, and, if any entries stay unpinned, a second
// division of the unpinned remainder. Each result is then read from the floor store
// and put into the output register once that register is free; the next read waits
// for that. An empty result (total zero or list longer than MAX_ENTRIES) goes into
// the output register from the check state once the register is free. The input
// side reopens as soon as the last result sits in the output register.
module floored_equal_share #(
	parameter int MAX_ENTRIES = 16,
	parameter int VALUE_BITS  = 15
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [fes_pkg::IN_W-1:0] size,
	input  logic signed [fes_pkg::IN_W-1:0] floor_value,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [fes_pkg::SHARE_W-1:0]    share,
	output logic                           empty_res,
	output logic                           last_out
);

	import fes_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int SUM_W = VALUE_BITS + CNT_W;
	localparam logic [31:0] VAL_MAX = (32'd1 << VALUE_BITS) - 32'd1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_CHECK,
		ST_DIV_EQ,
		ST_SCAN_RD,
		ST_SCAN_ACC,
		ST_DIV_REST,
		ST_EMIT_RD,
		ST_EMIT_PUT
	} state_t;

	function automatic logic [VALUE_BITS-1:0] clamp_in(input logic [IN_W-1:0] raw);
		logic [31:0] mag;
		mag = {17'd0, raw[IN_W-2:0]};
		if (raw[IN_W-1]) begin
			clamp_in = '0;
		end else if (mag > VAL_MAX) begin
			clamp_in = VAL_MAX[VALUE_BITS-1:0];
		end else begin
			clamp_in = mag[VALUE_BITS-1:0];
		end
	endfunction

	state_t              state_q;
	emit_mode_t          mode_q;
	logic [CNT_W-1:0]    entry_count_q;
	logic [SUM_W-1:0]    size_total_q;
	logic [SUM_W-1:0]    floor_sum_q;
	logic                overflowed_q;
	logic [SUM_W-1:0]    equal_q;
	logic [SUM_W-1:0]    rest_share_q;
	logic [CNT_W-1:0]    left_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    rest_count_q;
	logic [SUM_W-1:0]    pinned_q;
	logic [SHARE_W-1:0]  share_q;
	logic                empty_q;
	logic                last_out_q;
	logic                out_valid_q;

	logic [VALUE_BITS-1:0] sz_c;
	logic [VALUE_BITS-1:0] fl_c;
	logic                  in_acc;
	logic                  out_free;
	logic                  out_load;
	logic [VALUE_BITS-1:0] rd_floor;
	logic [SUM_W-1:0]      floor_ext;
	logic                  pin_c;
	logic                  idx_last;
	logic [SUM_W-1:0]      pinned_next;
	logic [CNT_W-1:0]      rest_next;
	logic [SUM_W-1:0]      emit_val;
	logic                  list_empty;
	logic                  mem_we;

	logic                  div_start;
	logic [SUM_W-1:0]      div_dividend;
	logic [CNT_W-1:0]      div_divisor;
	logic                  div_done;
	logic [SUM_W-1:0]      div_quo;
	logic [CNT_W-1:0]      div_rem;

	assign sz_c       = clamp_in(size);
	assign fl_c       = clamp_in(floor_value);
	assign in_ready   = (state_q == ST_LOAD);
	assign in_acc     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign mem_we     = in_acc && (entry_count_q < CNT_W'(MAX_ENTRIES));
	assign floor_ext  = SUM_W'(rd_floor);
	assign pin_c      = (floor_ext > equal_q);
	assign idx_last   = ((idx_q + CNT_W'(1)) == entry_count_q);
	assign pinned_next = pinned_q + (pin_c ? floor_ext : '0);
	assign rest_next  = rest_count_q + CNT_W'(!pin_c);
	assign list_empty = overflowed_q || (size_total_q == '0);
	assign out_load   = out_free && ((state_q == ST_CHECK && list_empty)
			|| state_q == ST_EMIT_PUT);

	always_comb begin
		if (mode_q == MODE_EVEN) begin
			emit_val = equal_q + SUM_W'(idx_q < left_q);
		end else if (pin_c) begin
			emit_val = floor_ext;
		end else begin
			emit_val = rest_share_q + SUM_W'(left_q != '0);
		end
	end

	always_comb begin
		div_start    = 1'b0;
		div_dividend = size_total_q;
		div_divisor  = entry_count_q;
		if (state_q == ST_CHECK) begin
			div_start = !list_empty;
		end else if (state_q == ST_SCAN_ACC) begin
			div_start    = idx_last && (rest_next != '0);
			div_dividend = size_total_q - pinned_next;
			div_divisor  = rest_next;
		end
	end

	fes_ram #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (VALUE_BITS),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (entry_count_q[IDX_W-1:0]),
		.wdata (fl_c),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rd_floor)
	);

	fes_div #(
		.DIVIDEND_W (SUM_W),
		.DIVISOR_W  (CNT_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			mode_q        <= MODE_EVEN;
			entry_count_q <= '0;
			size_total_q  <= '0;
			floor_sum_q   <= '0;
			overflowed_q  <= 1'b0;
			idx_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (mem_we) begin
							entry_count_q <= entry_count_q + CNT_W'(1);
							size_total_q  <= size_total_q + SUM_W'(sz_c);
							floor_sum_q   <= floor_sum_q + SUM_W'(fl_c);
						end else begin
							overflowed_q <= 1'b1;
						end
						if (last) begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (!list_empty) begin
						state_q <= ST_DIV_EQ;
					end else if (out_free) begin
						share_q       <= '0;
						empty_q       <= 1'b1;
						last_out_q    <= 1'b1;
						entry_count_q <= '0;
						size_total_q  <= '0;
						floor_sum_q   <= '0;
						overflowed_q  <= 1'b0;
						state_q       <= ST_LOAD;
					end
				end
				ST_DIV_EQ: begin
					if (div_done) begin
						equal_q      <= div_quo;
						left_q       <= div_rem;
						idx_q        <= '0;
						pinned_q     <= '0;
						rest_count_q <= '0;
						mode_q       <= MODE_EVEN;
						if (floor_sum_q < size_total_q) begin
							state_q <= ST_SCAN_RD;
						end else begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_ACC;
				end
				ST_SCAN_ACC: begin
					pinned_q     <= pinned_next;
					rest_count_q <= rest_next;
					if (!idx_last) begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= ST_SCAN_RD;
					end else if (rest_next == '0) begin
						idx_q   <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						mode_q  <= MODE_REST;
						state_q <= ST_DIV_REST;
					end
				end
				ST_DIV_REST: begin
					if (div_done) begin
						rest_share_q <= div_quo;
						left_q       <= div_rem;
						idx_q        <= '0;
						state_q      <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_PUT;
				end
				ST_EMIT_PUT: begin
					if (out_free) begin
						share_q     <= SHARE_W'(emit_val);
						empty_q     <= 1'b0;
						last_out_q  <= idx_last;
						if (mode_q == MODE_REST && !pin_c && left_q != '0) begin
							left_q <= left_q - CNT_W'(1);
						end
						if (idx_last) begin
							entry_count_q <= '0;
							size_total_q  <= '0;
							floor_sum_q   <= '0;
							overflowed_q  <= 1'b0;
							state_q       <= ST_LOAD;
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign share     = share_q;
	assign empty_res = empty_q;
	assign last_out  = last_out_q;

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		overflowed_q |-> (entry_count_q == CNT_W'(MAX_ENTRIES)))
		else $error("overflow flag set with room left in floor store");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_EQ && div_done) |-> (div_rem < entry_count_q))
		else $error("divider remainder not below entry count");

	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && empty_q) |-> (share_q == '0 && last_out_q))
		else $error("empty result carries a share or is not final");

	a_clear_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && entry_count_q == '0)
		|-> (size_total_q == '0 && floor_sum_q == '0 && !overflowed_q))
		else $error("accumulators not cleared at list start");

	a_left_used: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_PUT && out_free && idx_last && mode_q == MODE_REST)
		|-> (left_q == '0 || (!pin_c && left_q == CNT_W'(1))))
		else $error("leftover units not fully handed out");

endmodule
